// ===== hdl/array_list_engine_core_macros.svh =====
// Assertion macros shared by the array list engine checkers.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, muted while reset is held
`define ALC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held
`define ALC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/alc_pkg.sv =====
// Shared types and constants for the array list engine.
// No dependencies; the sequencer, the top level, the checker and the testbench import this package.
`timescale 1ns / 1ps

package alc_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 11;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_REM_HEAD = 3'd3,
        OP_REM_TAIL = 3'd4,
        OP_REM_POS  = 3'd5,
        OP_SEARCH   = 3'd6,
        OP_READ     = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_INS,
        M_REM,
        M_SRCH,
        M_READ
    } t_mode;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  value;
        logic [ADDR_W-1:0]         fidx;
        logic [CNT_W-1:0]          count;
    } t_result;

endpackage

// ===== hdl/alc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module alc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/alc_seq.sv =====
// Sequencer for the array list engine: decodes a request, then walks the
// store one entry per cycle through the RAM ports. Depends on alc_pkg.
`timescale 1ns / 1ps

module alc_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2:0]                    i_op,
    input  logic signed [31:0]            i_item_value,
    input  logic [10:0]                   i_position,
    input  logic                          i_res_take,
    output logic                          o_idle,
    output logic                          o_res_valid,
    output alc_pkg::t_result              o_res,
    output logic                          o_ram_re,
    output logic [alc_pkg::ADDR_W-1:0]    o_ram_raddr,
    output logic                          o_ram_we,
    output logic [alc_pkg::ADDR_W-1:0]    o_ram_waddr,
    output logic [alc_pkg::DATA_W-1:0]    o_ram_wdata,
    input  logic [alc_pkg::DATA_W-1:0]    i_ram_rdata
);

    import alc_pkg::*;

    t_state                  r_state,     n_state;
    t_mode                   r_mode,      n_mode;
    logic [CNT_W-1:0]        r_count,     n_count;
    logic [CNT_W-1:0]        r_rem,       n_rem;
    logic [ADDR_W-1:0]       r_addr,      n_addr;
    logic [ADDR_W-1:0]       r_pend_addr, n_pend_addr;
    logic                    r_pend,      n_pend;
    logic                    r_first,     n_first;
    logic [ADDR_W-1:0]       r_pos,       n_pos;
    logic [DATA_W-1:0]       r_value,     n_value;
    t_status                 r_status,    n_status;
    logic [DATA_W-1:0]       r_rval,      n_rval;
    logic [ADDR_W-1:0]       r_fidx,      n_fidx;

    t_op                     op;
    logic [CNT_W-1:0]        p;
    logic                    hit;

    assign op  = t_op'(i_op);
    assign hit = r_pend && (r_mode == M_SRCH) && (i_ram_rdata == r_value);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_rem   <= n_rem;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_addr      <= n_addr;
        r_pend_addr <= n_pend_addr;
        r_first     <= n_first;
        r_pos       <= n_pos;
        r_value     <= n_value;
        r_status    <= n_status;
        r_rval      <= n_rval;
        r_fidx      <= n_fidx;
    end

    // next state and RAM control
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_rem       = r_rem;
        n_addr      = r_addr;
        n_pend_addr = r_pend_addr;
        n_pend      = 1'b0;
        n_first     = r_first;
        n_pos       = r_pos;
        n_value     = r_value;
        n_status    = r_status;
        n_rval      = r_rval;
        n_fidx      = r_fidx;
        p           = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_addr;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pos;
        o_ram_wdata = i_ram_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value  = i_item_value;
                    n_status = ST_OK;
                    n_rval   = '0;
                    n_fidx   = '0;
                    n_first  = 1'b0;
                    n_state  = S_SCAN;
                    if (op inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS}) begin
                        // insert: shift count-p entries up, top first
                        p = (op == OP_INS_HEAD) ? '0 :
                            (op == OP_INS_TAIL) ? r_count : i_position;
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (p > r_count) begin
                            n_status = ST_BADPOS;
                            n_state  = S_DONE;
                        end else begin
                            n_mode = M_INS;
                            n_rem  = r_count - p;
                            n_addr = ADDR_W'(r_count - CNT_W'(1));
                            n_pos  = p[ADDR_W-1:0];
                        end
                    end else if (op inside {OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS}) begin
                        // remove: read entry p, then pull the rest down
                        p = (op == OP_REM_HEAD) ? '0 :
                            (op == OP_REM_TAIL) ? r_count - CNT_W'(1) : i_position;
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (p >= r_count) begin
                            n_status = ST_BADPOS;
                            n_state  = S_DONE;
                        end else begin
                            n_mode  = M_REM;
                            n_rem   = r_count - p;
                            n_addr  = p[ADDR_W-1:0];
                            n_first = 1'b1;
                        end
                    end else if (op == OP_SEARCH) begin
                        n_mode = M_SRCH;
                        n_rem  = r_count;
                        n_addr = '0;
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (i_position >= r_count) begin
                            n_status = ST_BADPOS;
                            n_state  = S_DONE;
                        end else begin
                            n_mode  = M_READ;
                            n_rem   = CNT_W'(1);
                            n_addr  = i_position[ADDR_W-1:0];
                            n_first = 1'b1;
                        end
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    // first match ends the search
                    n_fidx  = r_pend_addr;
                    n_state = S_DONE;
                end else begin
                    // issue the next read, stepping toward the far end
                    if (r_rem != '0) begin
                        o_ram_re    = 1'b1;
                        n_pend      = 1'b1;
                        n_pend_addr = r_addr;
                        n_rem       = r_rem - CNT_W'(1);
                        n_addr      = (r_mode == M_INS) ? r_addr - ADDR_W'(1)
                                                        : r_addr + ADDR_W'(1);
                    end
                    // retire the beat read last cycle
                    if (r_pend) begin
                        if (r_first) begin
                            n_rval  = i_ram_rdata;
                            n_first = 1'b0;
                        end else if (r_mode == M_INS) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_pend_addr + ADDR_W'(1);
                        end else if (r_mode == M_REM) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_pend_addr - ADDR_W'(1);
                        end
                    end
                    // walk finished
                    if ((r_rem == '0) && !r_pend) begin
                        case (r_mode)
                            M_INS:  n_state = S_PLACE;
                            M_REM: begin
                                n_count = r_count - CNT_W'(1);
                                n_state = S_DONE;
                            end
                            M_SRCH: begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_DONE;
                            end
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end

            S_PLACE: begin
                // drop the new value into the opened slot
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pos;
                o_ram_wdata = r_value;
                n_count     = r_count + CNT_W'(1);
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.value  = r_rval;
    assign o_res.fidx   = r_fidx;
    assign o_res.count  = r_count;

endmodule

// ===== hdl/array_list_engine_core.sv =====
// Array list engine top: input handshake, output register, sequencer and store.
// One request at a time: the next beat is taken the cycle after the result enters
// a free output register.
// Reset (synchronous, active low) clears the count; the store is not cleared.
`timescale 1ns / 1ps

module array_list_engine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_item_value,
    input  logic [10:0]        i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [9:0]         o_found_index,
    output logic [10:0]        o_entry_count
);

    import alc_pkg::*;

    logic                seq_idle;
    logic                res_valid;
    logic                res_take;
    t_result             res;
    t_result             r_out;
    logic                r_out_valid;
    logic                ram_re;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    // input beat taken only while the sequencer is idle
    assign o_in_stall = !seq_idle;

    // result moves into the output register when that slot is free
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    alc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && seq_idle),
        .i_op         (i_op),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .i_res_take   (res_take),
        .o_idle       (seq_idle),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .i_ram_rdata  (ram_rdata)
    );

    alc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_value = r_out.value;
    assign o_found_index  = r_out.fidx;
    assign o_entry_count  = r_out.count;

endmodule

// ===== hdl/alc_checker.sv =====
// Port-level checks for the array list engine, bound to the top level.
// Depends on alc_pkg and array_list_engine_core_macros.svh.
`timescale 1ns / 1ps
`include "array_list_engine_core_macros.svh"

module alc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [2:0]         i_op,
    input logic signed [31:0] i_item_value,
    input logic [10:0]        i_position,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic signed [31:0] o_result_value,
    input logic [9:0]         o_found_index,
    input logic [10:0]        o_entry_count
);

    import alc_pkg::*;

    // one request at a time: a taken beat closes the input side
    `ALC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")

    // full is only reported at full depth
    `ALC_ASSERT_NOW(a_full_count, o_out_valid && (o_status == ST_FULL), o_entry_count == CNT_W'(DEPTH), "full status with short count")

    // empty is only reported with no entries and no value
    `ALC_ASSERT_NOW(a_empty_count, o_out_valid && (o_status == ST_EMPTY), (o_entry_count == '0) && (o_result_value == '0), "empty status with entries")

    // a stalled result beat holds
    `ALC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_result_value) && $stable(o_entry_count), "stalled result changed")

endmodule

bind array_list_engine_core alc_checker u_alc_checker (.*);

// ===== sim/array_list_engine_core_test.sv =====
// Self-checking testbench for array_list_engine_core: directed list operations,
// random traffic on small lists, then a fill to full capacity and a drain.
// Depends on hdl/alc_pkg.sv and the block RTL.
`timescale 1ns / 1ps

module array_list_engine_core_test;

    import alc_pkg::*;

    // Idle cycles (nothing accepted on either side) before the run is abandoned
    localparam int IDLE_LIMIT = 6000;
    localparam int RANDOM_BEATS = 555;
    localparam t_result NO_WANT = '{ST_OK, 32'sd0, 10'd0, 11'd0};

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic [10:0]        pos;
        logic               typed;
        t_result            want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_op = 3'd0;
    logic signed [31:0] i_item_value = 32'sd0;
    logic [10:0]        i_position = 11'd0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_result_value;
    logic [9:0]         o_found_index;
    logic [10:0]        o_entry_count;

    // Shadow of the list contents; its size is the entry count
    logic signed [31:0] list_image[$];
    t_result            pending_results[$];
    t_result            head_result;
    int                 failures = 0;
    int                 idle_cycles = 0;
    int                 burst_left = 0;
    int                 stall_seg_left = 0;
    int                 stall_pct = 0;

    // Directed rows: empty-list errors, corner values, bounds, duplicates
    t_plan_row directed_plan [0:24] = '{
        '{OP_READ,     32'sd0,         11'd0,    1'b1, '{ST_EMPTY,    32'sd0, 10'd0, 11'd0}},
        '{OP_REM_HEAD, 32'sh0000_1234, 11'd0,    1'b1, '{ST_EMPTY,    32'sd0, 10'd0, 11'd0}},
        '{OP_REM_TAIL, 32'sd0,         11'd0,    1'b1, '{ST_EMPTY,    32'sd0, 10'd0, 11'd0}},
        '{OP_REM_POS,  32'sd0,         11'd0,    1'b1, '{ST_EMPTY,    32'sd0, 10'd0, 11'd0}},
        '{OP_SEARCH,   32'sd0,         11'd0,    1'b1, '{ST_NOTFOUND, 32'sd0, 10'd0, 11'd0}},
        '{OP_INS_POS,  32'sd5,         11'd1,    1'b1, '{ST_BADPOS,   32'sd0, 10'd0, 11'd0}},
        '{OP_INS_POS,  32'sd5,         11'd2047, 1'b1, '{ST_BADPOS,   32'sd0, 10'd0, 11'd0}},
        '{OP_INS_HEAD, 32'sh7FFF_FFFF, 11'd0,    1'b1, '{ST_OK,       32'sd0, 10'd0, 11'd1}},
        '{OP_INS_TAIL, 32'sh8000_0000, 11'd0,    1'b1, '{ST_OK,       32'sd0, 10'd0, 11'd2}},
        '{OP_INS_POS,  -32'sd1,        11'd2,    1'b1, '{ST_OK,       32'sd0, 10'd0, 11'd3}},
        '{OP_INS_POS,  32'sd0,         11'd0,    1'b0, NO_WANT},
        '{OP_INS_POS,  32'sh5555_AAAA, 11'd1,    1'b0, NO_WANT},
        '{OP_SEARCH,   -32'sd1,        11'd0,    1'b0, NO_WANT},
        '{OP_SEARCH,   32'sh8000_0000, 11'd0,    1'b0, NO_WANT},
        '{OP_SEARCH,   32'sd12345,     11'd0,    1'b1, '{ST_NOTFOUND, 32'sd0, 10'd0, 11'd5}},
        '{OP_READ,     32'sd0,         11'd5,    1'b1, '{ST_BADPOS,   32'sd0, 10'd0, 11'd5}},
        '{OP_READ,     32'sd0,         11'd1024, 1'b1, '{ST_BADPOS,   32'sd0, 10'd0, 11'd5}},
        '{OP_READ,     32'sd0,         11'd4,    1'b0, NO_WANT},
        '{OP_REM_POS,  32'sd0,         11'd5,    1'b1, '{ST_BADPOS,   32'sd0, 10'd0, 11'd5}},
        '{OP_REM_POS,  32'sd0,         11'd2,    1'b0, NO_WANT},
        '{OP_REM_HEAD, -32'sd1,        11'd2047, 1'b0, NO_WANT},
        '{OP_REM_TAIL, 32'sd0,         11'd1365, 1'b0, NO_WANT},
        '{OP_INS_HEAD, 32'sh2AAA_5555, 11'd2047, 1'b0, NO_WANT},
        '{OP_INS_TAIL, 32'sh2AAA_5555, 11'd682,  1'b0, NO_WANT},
        '{OP_SEARCH,   32'sh2AAA_5555, 11'd0,    1'b0, NO_WANT}
    };

    array_list_engine_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_found_index  (o_found_index),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Apply one request to the shadow list and return the result it should give
    function automatic t_result predict_list_op(t_op op, logic signed [31:0] v,
                                                logic [10:0] p);
        t_result r;
        int n;
        int idx;
        r = NO_WANT;
        n = list_image.size();
        case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                // fullness wins over a bad position
                if (n >= DEPTH) r.status = ST_FULL;
                else if (op == OP_INS_HEAD) list_image.push_front(v);
                else if (op == OP_INS_TAIL) list_image.push_back(v);
                else if (p > n) r.status = ST_BADPOS;
                else list_image.insert(p, v);
            end
            OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS: begin
                // emptiness wins over a bad position
                if (n == 0) r.status = ST_EMPTY;
                else if (op == OP_REM_HEAD) r.value = list_image.pop_front();
                else if (op == OP_REM_TAIL) r.value = list_image.pop_back();
                else if (p >= n) r.status = ST_BADPOS;
                else begin
                    r.value = list_image[p];
                    list_image.delete(p);
                end
            end
            OP_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (idx = 0; idx < n; idx++) begin
                    if (list_image[idx] == v) begin
                        r.status = ST_OK;
                        r.fidx = idx[9:0];
                        break;
                    end
                end
            end
            default: begin
                if (n == 0) r.status = ST_EMPTY;
                else if (p >= n) r.status = ST_BADPOS;
                else r.value = list_image[p];
            end
        endcase
        r.count = 11'(list_image.size());
        return r;
    endfunction

    // Drive one request beat in bursts with random gaps; record its result at accept
    task automatic send_request(input t_op op, input logic signed [31:0] v,
                                input logic [10:0] p, input logic typed,
                                input t_result typed_want);
        int gap;
        t_result model_out;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_item_value <= v;
        i_position   <= p;
        do @(posedge i_clk); while (o_in_stall);
        model_out = predict_list_op(op, v, p);
        pending_results.push_back(typed ? typed_want : model_out);
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random request, biased to keep the list short so shifts stay cheap
    task automatic pick_request(output t_op op, output logic signed [31:0] v,
                                output logic [10:0] p);
        int n;
        int r;
        int sub;
        int ins_w;
        int rem_w;
        int lim;
        n = list_image.size();
        ins_w = (n >= 40) ? 12 : ((n < 4) ? 50 : 36);
        rem_w = (n >= 40) ? 55 : 24;
        r = $urandom_range(0, 99);
        sub = $urandom_range(0, 2);
        if (r < ins_w)
            op = (sub == 0) ? OP_INS_HEAD : ((sub == 1) ? OP_INS_TAIL : OP_INS_POS);
        else if (r < ins_w + rem_w)
            op = (sub == 0) ? OP_REM_HEAD : ((sub == 1) ? OP_REM_TAIL : OP_REM_POS);
        else if (r < 88)
            op = OP_SEARCH;
        else
            op = OP_READ;

        // value: often a stored one so searches hit, sometimes a corner
        r = $urandom_range(0, 9);
        if (r < 4 && n > 0) v = list_image[$urandom_range(0, n - 1)];
        else if (r < 6) begin
            case ($urandom_range(0, 3))
                0: v = 32'sd0;
                1: v = -32'sd1;
                2: v = 32'sh7FFF_FFFF;
                default: v = 32'sh8000_0000;
            endcase
        end else v = $urandom;

        // position: mostly in range, some at the bound, some anywhere
        lim = (op == OP_INS_POS) ? n : n - 1;
        r = $urandom_range(0, 9);
        if (op != OP_INS_POS && op != OP_REM_POS && op != OP_READ)
            p = 11'($urandom_range(0, 2047));
        else if (r == 0) p = 11'($urandom_range(0, 2047));
        else if (r == 1) p = 11'(n + $urandom_range(0, 1));
        else if (lim < 0) p = 11'd0;
        else p = 11'($urandom_range(0, lim));
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
            failures++;
        end
    endtask

    // Result checker and progress counter for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing, got status %0d",
                         $time, o_status);
                failures++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("status", 32'(head_result.status), 32'(o_status));
                check_field("result_value", head_result.value, o_result_value);
                check_field("found_index", 32'(head_result.fidx), 32'(o_found_index));
                check_field("entry_count", 32'(head_result.count), 32'(o_entry_count));
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver stall: segments of random length, each with its own stall rate
    always @(posedge i_clk) begin
        if (stall_seg_left == 0) begin
            stall_seg_left = $urandom_range(8, 64);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 30;
                3: stall_pct = 70;
                default: stall_pct = 95;
            endcase
        end
        stall_seg_left--;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus
    initial begin
        int k;
        int n;
        t_op op;
        logic signed [31:0] v;
        logic [10:0] p;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k])
            send_request(directed_plan[k].op, directed_plan[k].value, directed_plan[k].pos,
                         directed_plan[k].typed, directed_plan[k].want);

        // random traffic on short lists, with one full hold-off midway
        for (k = 0; k < RANDOM_BEATS; k++) begin
            if (k == RANDOM_BEATS / 2) wait_results_drained();
            pick_request(op, v, p);
            send_request(op, v, p, 1'b0, NO_WANT);
        end
        wait_results_drained();

        // fill to capacity; low bits of each value hold its fill index
        while (list_image.size() < DEPTH) begin
            n = list_image.size();
            v = ($urandom << 10) | n;
            if (n >= 4 && $urandom_range(0, 4) == 0)
                send_request(OP_INS_POS, v, 11'(n - $urandom_range(0, 3)), 1'b0, NO_WANT);
            else
                send_request(OP_INS_TAIL, v, 11'($urandom_range(0, 2047)), 1'b0, NO_WANT);
        end

        // full list: rejected inserts, long scans, bounds at the top end
        send_request(OP_INS_HEAD, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_INS_TAIL, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_INS_POS, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_INS_POS, $urandom, 11'd2047, 1'b0, NO_WANT);
        send_request(OP_SEARCH, list_image[DEPTH-1], 11'd0, 1'b0, NO_WANT);
        send_request(OP_SEARCH, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_READ, $urandom, 11'd1023, 1'b0, NO_WANT);
        send_request(OP_READ, $urandom, 11'd1024, 1'b0, NO_WANT);
        send_request(OP_REM_POS, $urandom, 11'd1024, 1'b0, NO_WANT);
        send_request(OP_REM_POS, $urandom, 11'd1023, 1'b0, NO_WANT);
        send_request(OP_INS_POS, $urandom, 11'd1023, 1'b0, NO_WANT);
        send_request(OP_REM_HEAD, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_INS_HEAD, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_REM_POS, $urandom, 11'd0, 1'b0, NO_WANT);

        // drain mostly from the tail, with reads and positional removes near it
        while (list_image.size() > 0) begin
            n = list_image.size();
            if (n > 4 && $urandom_range(0, 9) == 0)
                send_request(OP_REM_POS, $urandom, 11'(n - 1 - $urandom_range(0, 3)),
                             1'b0, NO_WANT);
            else if ($urandom_range(0, 19) == 0)
                send_request(OP_READ, $urandom, 11'($urandom_range(0, n - 1)), 1'b0, NO_WANT);
            else
                send_request(OP_REM_TAIL, $urandom, 11'($urandom_range(0, 2047)),
                             1'b0, NO_WANT);
        end
        send_request(OP_REM_TAIL, $urandom, 11'd0, 1'b0, NO_WANT);
        send_request(OP_SEARCH, $urandom, 11'd0, 1'b0, NO_WANT);

        wait_results_drained();
        repeat (16) @(posedge i_clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
